/* src/gsa_pkg.sv */
// Package for the generational slot allocator.
// Holds sizes, operation codes, status codes and the slot entry type.
// No dependencies.
package gsa_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int IDX_BITS = $clog2(SLOT_COUNT);
   localparam int COUNT_BITS = $clog2(SLOT_COUNT + 1);
   localparam int GEN_BITS = 16;
   localparam int KIND_BITS = 16;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_STALE = 2'd2;

   typedef struct packed {
      logic                 alive;
      logic [GEN_BITS-1:0]  gen;
      logic [KIND_BITS-1:0] kind;
   } slot_entry_type;

endpackage

/* src/generational_slot_allocator.sv */
// Generational slot allocator top level.
// Depends on gsa_pkg for sizes, codes and the slot entry type.
//
// Usage: a request word on the req_ channel carries an operation (allocate,
// release or look up), a handle (slot index and generation) and a kind. Each
// accepted request gives exactly one response word on the rsp_ channel with a
// status, a slot index, a generation and the stored kind.
// A request is accepted when req_valid is high and req_stall is low; req_stall
// is high while a request is in progress. Release and lookup read the slot
// memory once, and a successful release writes it back. Allocate of a
// never-used slot reads no memory; allocate that pops the free stack reads
// the stack memory and then the slot memory, because the stack memory read
// must complete before the slot memory read. A finished response waits in
// an output register; when the receiver holds rsp_stall, the next request is
// still accepted and waits in its final step until the output register is
// free.
// Reset clears the state machine, the free count, the high-water mark and the
// output valid. Slot entries below the high-water mark are always written
// before use, so the memories need no clearing pass.
module generational_slot_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_op,
   input  logic [gsa_pkg::IDX_BITS-1:0]   req_slot_index,
   input  logic [gsa_pkg::GEN_BITS-1:0]   req_handle_generation,
   input  logic [gsa_pkg::KIND_BITS-1:0]  req_kind,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [gsa_pkg::IDX_BITS-1:0]   rsp_granted_index,
   output logic [gsa_pkg::GEN_BITS-1:0]   rsp_granted_generation,
   output logic [gsa_pkg::KIND_BITS-1:0]  rsp_stored_kind
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]                      op_ff, op_in;
   logic [gsa_pkg::IDX_BITS-1:0]    slot_ff, slot_in;
   logic [gsa_pkg::GEN_BITS-1:0]    gen_ff, gen_in;
   logic [gsa_pkg::KIND_BITS-1:0]   kind_ff, kind_in;
   logic                            fresh_ff, fresh_in;
   logic [gsa_pkg::COUNT_BITS-1:0]  free_count_ff, free_count_in;
   logic [gsa_pkg::COUNT_BITS-1:0]  high_water_ff, high_water_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;
   logic [gsa_pkg::IDX_BITS-1:0]    rsp_index_ff, rsp_index_in;
   logic [gsa_pkg::GEN_BITS-1:0]    rsp_gen_ff, rsp_gen_in;
   logic [gsa_pkg::KIND_BITS-1:0]   rsp_kind_ff, rsp_kind_in;

   gsa_pkg::slot_entry_type         slot_mem [gsa_pkg::SLOT_COUNT];
   gsa_pkg::slot_entry_type         slot_rd_ff;
   gsa_pkg::slot_entry_type         slot_wr_data;
   logic                            slot_rd_en;
   logic [gsa_pkg::IDX_BITS-1:0]    slot_rd_addr;
   logic                            slot_we;

   logic [gsa_pkg::IDX_BITS-1:0]    stack_mem [gsa_pkg::SLOT_COUNT];
   logic [gsa_pkg::IDX_BITS-1:0]    stack_rd_ff;
   logic                            stack_rd_en;
   logic                            stack_we;

   logic                            rsp_free;
   logic                            handle_ok;
   logic                            store_full;
   logic [gsa_pkg::COUNT_BITS-1:0]  count_dec;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_index = rsp_index_ff;
   assign rsp_granted_generation = rsp_gen_ff;
   assign rsp_stored_kind = rsp_kind_ff;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign count_dec = free_count_ff - gsa_pkg::COUNT_BITS'(1);
   assign store_full = (high_water_ff == gsa_pkg::COUNT_BITS'(gsa_pkg::SLOT_COUNT));
   assign handle_ok = (gsa_pkg::COUNT_BITS'(slot_ff) < high_water_ff) && slot_rd_ff.alive
                      && (slot_rd_ff.gen == gen_ff);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      slot_in = slot_ff;
      gen_in = gen_ff;
      kind_in = kind_ff;
      fresh_in = fresh_ff;
      free_count_in = free_count_ff;
      high_water_in = high_water_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      rsp_gen_in = rsp_gen_ff;
      rsp_kind_in = rsp_kind_ff;
      slot_rd_en = 1'b0;
      slot_rd_addr = req_slot_index;
      slot_we = 1'b0;
      slot_wr_data = slot_rd_ff;
      stack_rd_en = 1'b0;
      stack_we = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               gen_in = req_handle_generation;
               kind_in = req_kind;
               fresh_in = 1'b0;
               if (req_op == gsa_pkg::OP_ALLOC) begin
                  slot_in = high_water_ff[gsa_pkg::IDX_BITS-1:0];
                  if (free_count_ff != '0) begin
                     stack_rd_en = 1'b1;
                     state_in = ST_POP;
                  end else begin
                     fresh_in = 1'b1;
                     state_in = ST_EXEC;
                  end
               end else begin
                  slot_in = req_slot_index;
                  slot_rd_en = 1'b1;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_POP: begin
            slot_in = stack_rd_ff;
            slot_rd_addr = stack_rd_ff;
            slot_rd_en = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = gsa_pkg::STATUS_STALE;
               rsp_index_in = slot_ff;
               rsp_gen_in = gen_ff;
               rsp_kind_in = '0;
               state_in = ST_IDLE;
               case (op_ff)
                  gsa_pkg::OP_ALLOC: begin
                     if (fresh_ff && store_full) begin
                        rsp_status_in = gsa_pkg::STATUS_FULL;
                        rsp_index_in = '0;
                     end else begin
                        rsp_status_in = gsa_pkg::STATUS_OK;
                        rsp_gen_in = fresh_ff ? '0 : slot_rd_ff.gen;
                        rsp_kind_in = kind_ff;
                        slot_we = 1'b1;
                        slot_wr_data.alive = 1'b1;
                        slot_wr_data.gen = fresh_ff ? '0 : slot_rd_ff.gen;
                        slot_wr_data.kind = kind_ff;
                        if (fresh_ff) begin
                           high_water_in = high_water_ff + gsa_pkg::COUNT_BITS'(1);
                        end else begin
                           free_count_in = count_dec;
                        end
                     end
                  end
                  gsa_pkg::OP_RELEASE: begin
                     if (handle_ok) begin
                        rsp_status_in = gsa_pkg::STATUS_OK;
                        slot_we = 1'b1;
                        slot_wr_data.alive = 1'b0;
                        slot_wr_data.gen = slot_rd_ff.gen + gsa_pkg::GEN_BITS'(1);
                        slot_wr_data.kind = slot_rd_ff.kind;
                        if (free_count_ff < gsa_pkg::COUNT_BITS'(gsa_pkg::SLOT_COUNT)) begin
                           stack_we = 1'b1;
                           free_count_in = free_count_ff + gsa_pkg::COUNT_BITS'(1);
                        end
                     end
                  end
                  gsa_pkg::OP_LOOKUP: begin
                     if (handle_ok) begin
                        rsp_status_in = gsa_pkg::STATUS_OK;
                        rsp_kind_in = slot_rd_ff.kind;
                     end
                  end
                  default: begin
                     rsp_status_in = gsa_pkg::STATUS_STALE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         free_count_ff <= '0;
         high_water_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_count_ff <= free_count_in;
         high_water_ff <= high_water_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      slot_ff <= slot_in;
      gen_ff <= gen_in;
      kind_ff <= kind_in;
      fresh_ff <= fresh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff <= rsp_index_in;
      rsp_gen_ff <= rsp_gen_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_ff] <= slot_wr_data;
      end
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem[slot_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[free_count_ff[gsa_pkg::IDX_BITS-1:0]] <= slot_ff;
      end
      if (stack_rd_en) begin
         stack_rd_ff <= stack_mem[count_dec[gsa_pkg::IDX_BITS-1:0]];
      end
   end

endmodule

/* dv/gsa_checker.sv */
// Checker for the generational slot allocator: watches the request and response
// channels, predicts every response word and compares it field by field.
// Depends on gsa_pkg for sizes, operation codes, status codes and the slot entry type.
module gsa_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [gsa_pkg::IDX_BITS-1:0]  req_slot_index,
   input  logic [gsa_pkg::GEN_BITS-1:0]  req_handle_generation,
   input  logic [gsa_pkg::KIND_BITS-1:0] req_kind,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_status,
   input  logic [gsa_pkg::IDX_BITS-1:0]  rsp_granted_index,
   input  logic [gsa_pkg::GEN_BITS-1:0]  rsp_granted_generation,
   input  logic [gsa_pkg::KIND_BITS-1:0] rsp_stored_kind,
   output int                            mismatches,
   output int                            outstanding
);

   typedef struct {
      logic [1:0]                    status;
      logic [gsa_pkg::IDX_BITS-1:0]  index;
      logic [gsa_pkg::GEN_BITS-1:0]  generation;
      logic [gsa_pkg::KIND_BITS-1:0] stored_kind;
   } response_word_type;

   gsa_pkg::slot_entry_type      slots [gsa_pkg::SLOT_COUNT];
   logic [gsa_pkg::IDX_BITS-1:0] free_list [gsa_pkg::SLOT_COUNT];
   int                           free_depth;
   int                           high_mark;
   response_word_type            awaited_responses [$];

   function automatic bit handle_live(logic [gsa_pkg::IDX_BITS-1:0] idx,
                                      logic [gsa_pkg::GEN_BITS-1:0] gen);
      return idx < high_mark && slots[idx].alive && slots[idx].gen == gen;
   endfunction

   function automatic response_word_type slot_outcome(logic [1:0] op,
                                                      logic [gsa_pkg::IDX_BITS-1:0] idx,
                                                      logic [gsa_pkg::GEN_BITS-1:0] gen,
                                                      logic [gsa_pkg::KIND_BITS-1:0] kind);
      response_word_type r;
      int slot;
      r.status = gsa_pkg::STATUS_STALE;
      r.index = idx;
      r.generation = gen;
      r.stored_kind = '0;
      case (op)
         gsa_pkg::OP_ALLOC: begin
            if (free_depth > 0) begin
               free_depth--;
               slot = free_list[free_depth];
            end else if (high_mark < gsa_pkg::SLOT_COUNT) begin
               slot = high_mark;
               high_mark++;
            end else begin
               slot = -1;
            end
            if (slot >= 0) begin
               slots[slot].alive = 1'b1;
               slots[slot].kind = kind;
               r.status = gsa_pkg::STATUS_OK;
               r.index = slot[gsa_pkg::IDX_BITS-1:0];
               r.generation = slots[slot].gen;
               r.stored_kind = kind;
            end else begin
               r.status = gsa_pkg::STATUS_FULL;
               r.index = '0;
            end
         end
         gsa_pkg::OP_RELEASE: begin
            if (handle_live(idx, gen)) begin
               slots[idx].alive = 1'b0;
               slots[idx].gen = slots[idx].gen + 1'b1;
               free_list[free_depth] = idx;
               free_depth++;
               r.status = gsa_pkg::STATUS_OK;
            end
         end
         gsa_pkg::OP_LOOKUP: begin
            if (handle_live(idx, gen)) begin
               r.status = gsa_pkg::STATUS_OK;
               r.stored_kind = slots[idx].kind;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      response_word_type want;
      if (reset) begin
         for (int i = 0; i < gsa_pkg::SLOT_COUNT; i++) begin
            slots[i] = '0;
         end
         free_depth = 0;
         high_mark = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response word with no request outstanding");
               mismatches++;
            end else begin
               want = awaited_responses.pop_front();
               compare_field("rsp_status", want.status, rsp_status);
               compare_field("rsp_granted_index", want.index, rsp_granted_index);
               compare_field("rsp_granted_generation", want.generation,
                             rsp_granted_generation);
               compare_field("rsp_stored_kind", want.stored_kind, rsp_stored_kind);
            end
         end
         if (req_valid && !req_stall) begin
            awaited_responses.insert(awaited_responses.size(),
                                     slot_outcome(req_op, req_slot_index,
                                                  req_handle_generation, req_kind));
         end
      end
      outstanding = awaited_responses.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top for the generational slot allocator: drives request words with
// random gaps and response stalls, and gives the verdict from gsa_checker.
// Depends on gsa_pkg, generational_slot_allocator and gsa_checker.
module tb;

   localparam int RUN_LIMIT = 200000;
   localparam int RANDOM_WORDS = 500;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_BALANCED} traffic_mode_type;

   typedef struct {
      logic [gsa_pkg::IDX_BITS-1:0] index;
      logic [gsa_pkg::GEN_BITS-1:0] generation;
   } handle_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_op;
   logic [gsa_pkg::IDX_BITS-1:0]  req_slot_index;
   logic [gsa_pkg::GEN_BITS-1:0]  req_handle_generation;
   logic [gsa_pkg::KIND_BITS-1:0] req_kind;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_status;
   logic [gsa_pkg::IDX_BITS-1:0]  rsp_granted_index;
   logic [gsa_pkg::GEN_BITS-1:0]  rsp_granted_generation;
   logic [gsa_pkg::KIND_BITS-1:0] rsp_stored_kind;

   int         failures;
   int         backlog;
   int         cycles = 0;
   int         words_sent = 0;
   int         words_back = 0;
   bit         calm = 1'b0;
   logic [1:0] ops_in_flight [$];
   handle_type live_handles [$];
   handle_type retired_handles [$];

   generational_slot_allocator i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_op                 (req_op),
      .req_slot_index         (req_slot_index),
      .req_handle_generation  (req_handle_generation),
      .req_kind               (req_kind),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_granted_index      (rsp_granted_index),
      .rsp_granted_generation (rsp_granted_generation),
      .rsp_stored_kind        (rsp_stored_kind)
   );

   gsa_checker i_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_op                 (req_op),
      .req_slot_index         (req_slot_index),
      .req_handle_generation  (req_handle_generation),
      .req_kind               (req_kind),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_granted_index      (rsp_granted_index),
      .rsp_granted_generation (rsp_granted_generation),
      .rsp_stored_kind        (rsp_stored_kind),
      .mismatches             (failures),
      .outstanding            (backlog)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == RUN_LIMIT) begin
         $display("generational_slot_allocator verification failed");
         $finish;
      end
   end

   // Handles come back on the response channel, so live ones are collected there.
   always @(posedge clock) begin : track_handles
      logic [1:0] op;
      handle_type granted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall && ops_in_flight.size() > 0) begin
            op = ops_in_flight.pop_front();
            words_back++;
            if (op == gsa_pkg::OP_ALLOC && rsp_status == gsa_pkg::STATUS_OK) begin
               granted.index = rsp_granted_index;
               granted.generation = rsp_granted_generation;
               live_handles.insert(live_handles.size(), granted);
            end
         end
         if (req_valid && !req_stall) begin
            ops_in_flight.insert(ops_in_flight.size(), req_op);
            words_sent++;
         end
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic send_word(logic [1:0] op, logic [gsa_pkg::IDX_BITS-1:0] idx,
                            logic [gsa_pkg::GEN_BITS-1:0] gen,
                            logic [gsa_pkg::KIND_BITS-1:0] kind);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_slot_index <= idx;
      req_handle_generation <= gen;
      req_kind <= kind;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic issue_random(traffic_mode_type mode);
      int roll;
      int pick;
      int alloc_pct;
      int release_pct;
      int lookup_pct;
      handle_type h;
      case (mode)
         MODE_FILL: begin
            alloc_pct = 85;
            release_pct = 3;
            lookup_pct = 7;
         end
         MODE_DRAIN: begin
            alloc_pct = 15;
            release_pct = 55;
            lookup_pct = 15;
         end
         default: begin
            alloc_pct = 40;
            release_pct = 30;
            lookup_pct = 20;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
         send_word(gsa_pkg::OP_ALLOC, gsa_pkg::IDX_BITS'($urandom),
                   gsa_pkg::GEN_BITS'($urandom), gsa_pkg::KIND_BITS'($urandom));
      end else if (roll < alloc_pct + release_pct && live_handles.size() > 0) begin
         pick = $urandom_range(0, live_handles.size() - 1);
         h = live_handles[pick];
         live_handles.delete(pick);
         retired_handles.insert(retired_handles.size(), h);
         send_word(gsa_pkg::OP_RELEASE, h.index, h.generation,
                   gsa_pkg::KIND_BITS'($urandom));
      end else if (roll < alloc_pct + release_pct + lookup_pct && live_handles.size() > 0) begin
         h = live_handles[$urandom_range(0, live_handles.size() - 1)];
         send_word(gsa_pkg::OP_LOOKUP, h.index, h.generation,
                   gsa_pkg::KIND_BITS'($urandom));
      end else if (retired_handles.size() > 0 && $urandom_range(0, 1)) begin
         h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
         send_word($urandom_range(0, 1) ? gsa_pkg::OP_RELEASE : gsa_pkg::OP_LOOKUP,
                   h.index, h.generation, gsa_pkg::KIND_BITS'($urandom));
      end else begin
         send_word(2'($urandom_range(0, 3)), gsa_pkg::IDX_BITS'($urandom),
                   $urandom_range(0, 1) ? gsa_pkg::GEN_BITS'($urandom_range(0, 3))
                                        : gsa_pkg::GEN_BITS'($urandom),
                   gsa_pkg::KIND_BITS'($urandom));
      end
   endtask

   initial begin : drive_requests
      traffic_mode_type mode;
      int issued;
      int burst;
      req_valid = 1'b0;
      req_op = gsa_pkg::OP_ALLOC;
      req_slot_index = '0;
      req_handle_generation = '0;
      req_kind = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(gsa_pkg::OP_ALLOC, '0, '0, 16'h0000);
      send_word(gsa_pkg::OP_ALLOC, '1, '1, 16'hFFFF);
      send_word(gsa_pkg::OP_LOOKUP, 6'd0, 16'd0, '0);
      send_word(gsa_pkg::OP_LOOKUP, 6'd1, 16'd0, '1);
      send_word(gsa_pkg::OP_LOOKUP, 6'd1, 16'hFFFF, '0);
      send_word(gsa_pkg::OP_LOOKUP, 6'd63, 16'd0, '0);
      send_word(gsa_pkg::OP_RELEASE, 6'd1, 16'd0, '0);
      send_word(gsa_pkg::OP_RELEASE, 6'd1, 16'd0, '0);
      send_word(gsa_pkg::OP_LOOKUP, 6'd1, 16'd1, '0);
      send_word(gsa_pkg::OP_ALLOC, '0, '0, 16'h5A5A);
      send_word(gsa_pkg::OP_LOOKUP, 6'd1, 16'd1, '0);
      send_word(gsa_pkg::OP_RELEASE, 6'd0, 16'hFFFF, '0);
      send_word(gsa_pkg::OP_RELEASE, 6'd63, 16'hFFFF, '1);
      send_word(OP_SPARE, 6'd63, 16'hFFFF, 16'hFFFF);
      send_word(OP_SPARE, 6'd0, 16'd0, 16'd0);
      send_word(gsa_pkg::OP_RELEASE, 6'd0, 16'd0, '0);
      send_word(gsa_pkg::OP_RELEASE, 6'd1, 16'd1, '0);
      send_word(gsa_pkg::OP_ALLOC, '0, '0, 16'h1234);
      send_word(gsa_pkg::OP_ALLOC, '0, '0, 16'h8001);
      send_word(gsa_pkg::OP_ALLOC, '0, '0, 16'h7FFE);
      send_word(gsa_pkg::OP_LOOKUP, 6'd2, 16'd0, '0);

      issued = 0;
      mode = MODE_FILL;
      burst = 90;
      while (issued < RANDOM_WORDS) begin
         repeat (burst) begin
            issue_random(mode);
            issued++;
            if (issued % 40 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
            end
         end
         mode = traffic_mode_type'($urandom_range(0, 2));
         burst = $urandom_range(20, 60);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (words_back == words_sent);
      repeat (10) @(posedge clock);
      if (failures == 0 && backlog == 0) begin
         $display("generational_slot_allocator verification clean");
      end else begin
         $display("generational_slot_allocator verification failed");
      end
      $finish;
   end

   // One long hold-off lets the output register fill and backs up the request side.
   initial begin : drain_responses
      int hold;
      bit long_done;
      rsp_stall = 1'b0;
      long_done = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!long_done && words_back >= 150) begin
            hold = 120;
            long_done = 1'b1;
         end else begin
            hold = draw_gap();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

endmodule

/* generational_slot_allocator.f */
src/gsa_pkg.sv
src/generational_slot_allocator.sv
dv/gsa_checker.sv
dv/tb.sv
